FILE: hdl/tcw_pkg.sv
package tcw_pkg;

  // Command codes carried in the cmd field of an input item.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Status codes returned with every result item.
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_OUTSIDE    = 2'd1;
  localparam logic [1:0] STAT_NOT_STORED = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_COL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_ROW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR   = 3'd5;

  // Register reset values.
  localparam logic [6:0]  RST_ORIGIN_COL = 7'd5;
  localparam logic [5:0]  RST_ORIGIN_ROW = 6'd1;
  localparam logic [6:0]  RST_LINE_LIMIT = 7'd76;
  localparam logic [5:0]  RST_ROW_LIMIT  = 6'd32;
  localparam logic [31:0] RST_FG_COLOR   = 32'hFFFF_FF00;
  localparam logic [31:0] RST_BG_COLOR   = 32'h0000_0000;
  localparam logic [7:0]  RST_CURSOR_COL = 8'd24;
  localparam logic [7:0]  RST_CURSOR_ROW = 8'd16;

  // Character codes with special meaning.
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
    logic [6:0] pos_x;
    logic [6:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  cell_col;
    logic [7:0]  cell_row;
    logic [7:0]  cell_char;
    logic [4:0]  cell_palette;
    logic [31:0] cell_fg;
    logic [31:0] cell_bg;
    logic [1:0]  status;
  } out_item_t;

  // Requests from the sequencer to the palette cache.
  typedef struct packed {
    logic lookup;
    logic slot_reset;
  } pal_ctrl_t;

  // Status from the palette cache back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } pal_stat_t;

endpackage

FILE: hdl/text_console_cell_writer.sv
// Text console cell writer.
// Input channel (in_valid_i / in_stall_o / in_item_i) takes one command item:
// write a character at the cursor, set the cursor, clear the screen or read a
// cell. Every item gives exactly one result item on the output channel
// (out_valid_o / out_stall_i / out_item_o), naming the cell and its content.
// Configuration is written through cfg_valid_i / cfg_ready_o with a register
// index and data; it is always ready. The user must write it only while idle;
// the block does not enforce this. Items are taken one at a time; in_stall_o
// is high while an item is at work. A set cursor or read of a cell inside the
// store, and a character that is not stored at a cursor inside the store, read
// the store cell and then its palette entry; any item naming a cell outside the
// store goes straight to its result. A stored character takes a palette search,
// in which one comparator walks the palette cache one entry per cycle, then a
// palette read. Clear takes that search, then writes every store cell, one per
// cycle, then a palette read. After reset a clearing pass zeroes the store; no
// item is taken until it ends. A finished result waits in an output register
// while the receiver stalls; the next item may start meanwhile and holds its
// own result until the register is free.
module text_console_cell_writer import tcw_pkg::*; #(
  parameter int COLS          = 80,
  parameter int ROWS          = 35,
  parameter int PALETTE_SLOTS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int Depth = COLS * ROWS;
  localparam int AW    = $clog2(Depth);
  localparam int PW    = $clog2(PALETTE_SLOTS);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CellW = 8 + PW;

  typedef enum logic [8:0] {
    ST_INIT      = 9'b000000001,
    ST_IDLE      = 9'b000000010,
    ST_LOOKUP    = 9'b000000100,
    ST_SWEEP     = 9'b000001000,
    ST_CELL_RD   = 9'b000010000,
    ST_CELL_DATA = 9'b000100000,
    ST_PAL_RD    = 9'b001000000,
    ST_PAL_DATA  = 9'b010000000,
    ST_DONE      = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [6:0]  origin_col_q;
  logic [5:0]  origin_row_q;
  logic [6:0]  line_limit_q;
  logic [5:0]  row_limit_q;
  logic [31:0] fg_color_q;
  logic [31:0] bg_color_q;

  // Cursor and sweep counter.
  logic [7:0]    cur_col_q;
  logic [7:0]    cur_row_q;
  logic [AW-1:0] sweep_q;

  // Item under work.
  logic [1:0]       cmd_q;
  logic [7:0]       ch_q;
  logic [7:0]       res_col_q;
  logic [7:0]       res_row_q;
  logic [1:0]       status_q;
  logic [AW-1:0]    addr_q;
  logic [CellW-1:0] cell_q;
  logic [31:0]      res_fg_q;
  logic [31:0]      res_bg_q;
  out_item_t        out_q;
  logic             out_valid_q;

  logic             in_fire;
  logic             out_load;
  logic             sweep_end;
  logic             cur_in;
  logic             printable;
  logic             need_lookup;
  logic [7:0]       set_col;
  logic [7:0]       set_row;
  logic             set_in;
  logic [7:0]       rd_col;
  logic [7:0]       rd_row;
  logic             rd_in;
  logic [7:0]       adv_col;
  logic [7:0]       adv_row;
  logic             wrap;
  logic             store_we;
  logic [AW-1:0]    store_waddr;
  logic [CellW-1:0] store_wdata;
  logic [CellW-1:0] store_rdata;
  pal_ctrl_t        pal_ctrl;
  pal_stat_t        pal_stat;
  logic [PW-1:0]    pal_idx;
  logic [PW-1:0]    pal_rd_idx;
  logic [31:0]      pal_fg;
  logic [31:0]      pal_bg;

  // Row-major store address of a cell known to lie inside the store.
  function automatic logic [AW-1:0] cell_addr(input logic [7:0] col, input logic [7:0] row);
    return AW'(row[RW-1:0]) * AW'(COLS) + AW'(col[CW-1:0]);
  endfunction

  // Decode of the incoming item against the current cursor.
  assign cur_in    = (cur_col_q < 8'(COLS)) && (cur_row_q < 8'(ROWS));
  assign printable = (in_item_i.ch == 8'd0) ||
                     ((in_item_i.ch >= CHAR_SPACE) && (in_item_i.ch <= CHAR_TILDE));
  assign set_col   = {1'b0, origin_col_q} + {1'b0, in_item_i.pos_x};
  assign set_row   = {2'b0, origin_row_q} + {1'b0, in_item_i.pos_y};
  assign set_in    = (set_col < 8'(COLS)) && (set_row < 8'(ROWS));
  assign rd_col    = {1'b0, in_item_i.pos_x};
  assign rd_row    = {1'b0, in_item_i.pos_y};
  assign rd_in     = (rd_col < 8'(COLS)) && (rd_row < 8'(ROWS));
  assign need_lookup = (in_item_i.cmd == CMD_CLEAR) ||
                       ((in_item_i.cmd == CMD_WRITE) && printable && cur_in);

  // Cursor advance after a character write.
  assign adv_col = cur_col_q + 8'd1;
  assign adv_row = cur_row_q + 8'd1;
  assign wrap    = (in_item_i.ch == CHAR_CR) || (in_item_i.ch == CHAR_LF) ||
                   (adv_col >= {1'b0, line_limit_q});

  assign in_fire   = in_valid_i && (state_q == ST_IDLE);
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign sweep_end = (sweep_q == AW'(Depth - 1));

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Palette cache requests and read index.
  assign pal_ctrl.lookup     = in_fire && need_lookup;
  assign pal_ctrl.slot_reset = (state_q == ST_SWEEP);
  assign pal_rd_idx = (state_q == ST_CELL_DATA) ? store_rdata[PW-1:0] : cell_q[PW-1:0];

  tcw_palette #(
    .SLOTS (PALETTE_SLOTS)
  ) u_palette (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (pal_ctrl),
    .fg_i     (fg_color_q),
    .bg_i     (bg_color_q),
    .rd_idx_i (pal_rd_idx),
    .stat_o   (pal_stat),
    .idx_o    (pal_idx),
    .rd_fg_o  (pal_fg),
    .rd_bg_o  (pal_bg)
  );

  // Store write port: clearing passes and character writes.
  always_comb begin
    store_we    = 1'b0;
    store_waddr = addr_q;
    store_wdata = {ch_q, pal_idx};
    case (state_q)
      ST_INIT: begin
        store_we    = 1'b1;
        store_waddr = sweep_q;
        store_wdata = '0;
      end
      ST_SWEEP: begin
        store_we    = 1'b1;
        store_waddr = sweep_q;
        store_wdata = cell_q;
      end
      ST_LOOKUP: begin
        store_we = pal_stat.done && (cmd_q == CMD_WRITE);
      end
      default: begin
        store_we = 1'b0;
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (CellW),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (store_wdata),
    .raddr_i (addr_q),
    .rdata_o (store_rdata)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sweep_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_item_i.cmd)
            CMD_WRITE: begin
              if (!printable) state_d = cur_in ? ST_CELL_RD : ST_DONE;
              else            state_d = cur_in ? ST_LOOKUP : ST_DONE;
            end
            CMD_SET:   state_d = set_in ? ST_CELL_RD : ST_DONE;
            CMD_CLEAR: state_d = ST_LOOKUP;
            default:   state_d = rd_in ? ST_CELL_RD : ST_DONE;
          endcase
        end
      end
      ST_LOOKUP: begin
        if (pal_stat.done) state_d = (cmd_q == CMD_CLEAR) ? ST_SWEEP : ST_PAL_RD;
      end
      ST_SWEEP: begin
        if (sweep_end) state_d = ST_PAL_RD;
      end
      ST_CELL_RD:   state_d = ST_CELL_DATA;
      ST_CELL_DATA: state_d = ST_PAL_DATA;
      ST_PAL_RD:    state_d = ST_PAL_DATA;
      ST_PAL_DATA:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Control state: sequencer, cursor, configuration and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      sweep_q      <= '0;
      out_valid_q  <= 1'b0;
      cur_col_q    <= RST_CURSOR_COL;
      cur_row_q    <= RST_CURSOR_ROW;
      origin_col_q <= RST_ORIGIN_COL;
      origin_row_q <= RST_ORIGIN_ROW;
      line_limit_q <= RST_LINE_LIMIT;
      row_limit_q  <= RST_ROW_LIMIT;
      fg_color_q   <= RST_FG_COLOR;
      bg_color_q   <= RST_BG_COLOR;
    end else begin
      state_q <= state_d;

      if ((state_q == ST_INIT) || (state_q == ST_SWEEP)) begin
        sweep_q <= sweep_end ? '0 : sweep_q + 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (in_fire) begin
        case (in_item_i.cmd)
          CMD_WRITE: begin
            if (wrap) begin
              cur_col_q <= {1'b0, origin_col_q};
              cur_row_q <= (adv_row >= {2'b0, row_limit_q}) ? {2'b0, origin_row_q} : adv_row;
            end else begin
              cur_col_q <= adv_col;
            end
          end
          CMD_SET: begin
            cur_col_q <= set_col;
            cur_row_q <= set_row;
          end
          CMD_CLEAR: begin
            cur_col_q <= {1'b0, origin_col_q};
            cur_row_q <= {2'b0, origin_row_q};
          end
          default: begin
            cur_col_q <= cur_col_q;
          end
        endcase
      end

      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ORIGIN_COL: origin_col_q <= cfg_data_i[6:0];
          CFG_ORIGIN_ROW: origin_row_q <= cfg_data_i[5:0];
          CFG_LINE_LIMIT: line_limit_q <= cfg_data_i[6:0];
          CFG_ROW_LIMIT:  row_limit_q  <= cfg_data_i[5:0];
          CFG_FG_COLOR:   fg_color_q   <= cfg_data_i;
          CFG_BG_COLOR:   bg_color_q   <= cfg_data_i;
          default:        fg_color_q   <= fg_color_q;
        endcase
      end
    end
  end

  // Datapath registers of the item under work.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q    <= in_item_i.cmd;
      ch_q     <= in_item_i.ch;
      cell_q   <= '0;
      res_fg_q <= '0;
      res_bg_q <= '0;
      case (in_item_i.cmd)
        CMD_WRITE: begin
          res_col_q <= cur_col_q;
          res_row_q <= cur_row_q;
          status_q  <= !printable ? STAT_NOT_STORED : (cur_in ? STAT_OK : STAT_OUTSIDE);
          addr_q    <= cell_addr(cur_col_q, cur_row_q);
        end
        CMD_SET: begin
          res_col_q <= set_col;
          res_row_q <= set_row;
          status_q  <= set_in ? STAT_OK : STAT_OUTSIDE;
          addr_q    <= cell_addr(set_col, set_row);
        end
        CMD_CLEAR: begin
          res_col_q <= 8'd0;
          res_row_q <= 8'd0;
          status_q  <= STAT_OK;
          addr_q    <= '0;
        end
        default: begin
          res_col_q <= rd_col;
          res_row_q <= rd_row;
          status_q  <= rd_in ? STAT_OK : STAT_OUTSIDE;
          addr_q    <= cell_addr(rd_col, rd_row);
        end
      endcase
    end

    // The palette index found is kept with the character it goes with.
    if ((state_q == ST_LOOKUP) && pal_stat.done) begin
      cell_q <= {((cmd_q == CMD_WRITE) ? ch_q : 8'd0), pal_idx};
    end
    if (state_q == ST_CELL_DATA) begin
      cell_q <= store_rdata;
    end
    if (state_q == ST_PAL_DATA) begin
      res_fg_q <= pal_fg;
      res_bg_q <= pal_bg;
    end

    if (out_load) begin
      out_q.cell_col     <= res_col_q;
      out_q.cell_row     <= res_row_q;
      out_q.cell_char    <= cell_q[CellW-1 -: 8];
      out_q.cell_palette <= 5'(cell_q[PW-1:0]);
      out_q.cell_fg      <= res_fg_q;
      out_q.cell_bg      <= res_bg_q;
      out_q.status       <= status_q;
    end
  end

  // The palette cache works only on behalf of a lookup step.
  a_pal_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pal_stat.done || pal_stat.busy) |-> (state_q == ST_LOOKUP))
    else $error("palette cache active outside a lookup");

  // Store writes stay inside the store.
  a_store_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> ({1'b0, store_waddr} < (AW + 1)'(Depth)))
    else $error("store write beyond its depth");

  // A finished clear leaves the cursor at the origin.
  a_clear_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SWEEP) && sweep_end) |=>
      (cur_col_q == {1'b0, origin_col_q}) && (cur_row_q == {2'b0, origin_row_q}))
    else $error("cursor not at origin after clear");

endmodule

FILE: hdl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tcw_palette.sv
module tcw_palette import tcw_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pal_ctrl_t                ctrl_i,
  input  logic [31:0]              fg_i,
  input  logic [31:0]              bg_i,
  input  logic [$clog2(SLOTS)-1:0] rd_idx_i,
  output pal_stat_t                stat_o,
  output logic [$clog2(SLOTS)-1:0] idx_o,
  output logic [31:0]              rd_fg_o,
  output logic [31:0]              rd_bg_o
);

  localparam int PW = $clog2(SLOTS);

  logic             busy_q;
  logic [PW:0]      cnt_q;
  logic             cmp_vld_q;
  logic [PW-1:0]    cmp_idx_q;
  logic [PW-1:0]    next_slot_q;
  logic [SLOTS-1:0] valid_q;
  logic             rd_ok_q;
  logic [PW-1:0]    raddr;
  logic [63:0]      ram_rdata;
  logic [63:0]      entry;
  logic             hit;
  logic             miss;
  logic             done;
  logic             issue;

  // Entries never written read as zero.
  assign entry = rd_ok_q ? ram_rdata : '0;

  // The one comparator checks the entry read in the previous cycle.
  assign hit   = cmp_vld_q && (entry == {fg_i, bg_i});
  assign miss  = cmp_vld_q && !hit && (cmp_idx_q == PW'(SLOTS - 1));
  assign done  = hit || miss;
  assign issue = busy_q && !done && (cnt_q < (PW + 1)'(SLOTS));
  assign raddr = busy_q ? cnt_q[PW-1:0] : rd_idx_i;

  assign stat_o.busy = busy_q;
  assign stat_o.done = done;
  assign idx_o       = hit ? cmp_idx_q : next_slot_q;
  assign rd_fg_o     = entry[63:32];
  assign rd_bg_o     = entry[31:0];

  tcw_ram #(
    .WIDTH (64),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (miss),
    .waddr_i (next_slot_q),
    .wdata_i ({fg_i, bg_i}),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // Search sequencer, valid bits and round-robin slot pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      next_slot_q <= '0;
      valid_q     <= '0;
      rd_ok_q     <= 1'b0;
    end else begin
      rd_ok_q <= ({1'b0, raddr} < (PW + 1)'(SLOTS)) && valid_q[raddr];
      if (ctrl_i.lookup) begin
        busy_q    <= 1'b1;
        cnt_q     <= '0;
        cmp_vld_q <= 1'b0;
      end else if (busy_q) begin
        if (done) begin
          busy_q <= 1'b0;
        end
        cmp_vld_q <= issue;
        cmp_idx_q <= cnt_q[PW-1:0];
        if (issue) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (miss) begin
        valid_q[next_slot_q] <= 1'b1;
        next_slot_q <= (next_slot_q == PW'(SLOTS - 1)) ? '0 : next_slot_q + 1'b1;
      end else if (ctrl_i.slot_reset) begin
        next_slot_q <= '0;
      end
    end
  end

  // The slot pointer always names a real entry.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, next_slot_q} < (PW + 1)'(SLOTS))
    else $error("palette slot pointer out of range");

  // A new entry is marked valid right after it is allocated.
  a_alloc_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    miss |=> valid_q[$past(next_slot_q)])
    else $error("allocated palette entry not marked valid");

  // A lookup starts with a clean compare pipeline.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.lookup |=> busy_q && !cmp_vld_q)
    else $error("palette lookup did not start cleanly");

endmodule

FILE: dv/tb_text_console_cell_writer.sv
module tb_text_console_cell_writer import tcw_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS      = 80;
  localparam int ROWS      = 35;
  localparam int PAL_SLOTS = 32;
  localparam int IDLE_PCT  = 6;
  localparam int N_PHASES  = 40;
  localparam int LIMIT     = 1_000_000;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i  = '0;

  text_console_cell_writer #(
    .COLS          (COLS),
    .ROWS          (ROWS),
    .PALETTE_SLOTS (PAL_SLOTS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Console shadow: screen cells, palette cache, cursor and registers.
  logic [7:0]  scr_char [ROWS][COLS];
  logic [4:0]  scr_pal  [ROWS][COLS];
  logic [31:0] pal_fg   [PAL_SLOTS];
  logic [31:0] pal_bg   [PAL_SLOTS];
  logic [4:0]  slot_ptr;
  logic [7:0]  cur_col, cur_row;
  logic [6:0]  org_col, wrap_col;
  logic [5:0]  org_row, wrap_row;
  logic [31:0] fg_word, bg_word;

  in_item_t  cmd_backlog[$];
  out_item_t cells_due[$];
  int        bad_cells  = 0;
  int        cells_seen = 0;
  int        cycles     = 0;
  bit        steady     = 1'b0;
  logic [31:0] fg_pool [12];
  logic [31:0] bg_pool [4];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Palette lookup; a miss takes the round-robin slot and returns its own index.
  function automatic logic [4:0] pick_palette();
    logic [4:0] slot;
    logic       hit;
    hit  = 1'b0;
    slot = slot_ptr;
    for (int i = PAL_SLOTS - 1; i >= 0; i--) begin
      if (pal_fg[i] == fg_word && pal_bg[i] == bg_word) begin
        hit  = 1'b1;
        slot = 5'(i);
      end
    end
    if (!hit) begin
      pal_fg[slot] = fg_word;
      pal_bg[slot] = bg_word;
      slot_ptr     = slot + 5'd1;
    end
    return slot;
  endfunction

  // Result describing one cell; cells outside the store report no content.
  function automatic out_item_t cell_report(logic [7:0] col, logic [7:0] row, logic [1:0] st);
    out_item_t r;
    r          = '0;
    r.cell_col = col;
    r.cell_row = row;
    r.status   = st;
    if (col < COLS && row < ROWS) begin
      r.cell_char    = scr_char[row][col];
      r.cell_palette = scr_pal[row][col];
      r.cell_fg      = pal_fg[scr_pal[row][col]];
      r.cell_bg      = pal_bg[scr_pal[row][col]];
    end
    return r;
  endfunction

  function automatic bit in_store(logic [7:0] col, logic [7:0] row);
    return col < COLS && row < ROWS;
  endfunction

  // Apply one accepted item to the shadow and queue the cell it reports.
  function automatic void predict_cell(in_item_t it);
    logic [4:0] p;
    logic [7:0] col, row;
    bit         printable;
    col = cur_col;
    row = cur_row;
    case (it.cmd)
      CMD_WRITE: begin
        printable = (it.ch == 8'h00) || (it.ch >= CHAR_SPACE && it.ch <= CHAR_TILDE);
        if (!printable) begin
          cells_due.push_back(cell_report(col, row, STAT_NOT_STORED));
        end else if (!in_store(col, row)) begin
          cells_due.push_back(cell_report(col, row, STAT_OUTSIDE));
        end else begin
          p = pick_palette();
          scr_char[row][col] = it.ch;
          scr_pal[row][col]  = p;
          cells_due.push_back(cell_report(col, row, STAT_OK));
        end
        cur_col = cur_col + 8'd1;
        if (it.ch == CHAR_CR || it.ch == CHAR_LF || cur_col >= {1'b0, wrap_col}) begin
          cur_col = {1'b0, org_col};
          cur_row = cur_row + 8'd1;
          if (cur_row >= {2'b00, wrap_row}) cur_row = {2'b00, org_row};
        end
      end
      CMD_SET: begin
        cur_col = {1'b0, org_col} + {1'b0, it.pos_x};
        cur_row = {2'b00, org_row} + {1'b0, it.pos_y};
        cells_due.push_back(cell_report(cur_col, cur_row,
                            in_store(cur_col, cur_row) ? STAT_OK : STAT_OUTSIDE));
      end
      CMD_CLEAR: begin
        p = pick_palette();
        for (int r = 0; r < ROWS; r++) begin
          for (int c = 0; c < COLS; c++) begin
            scr_char[r][c] = 8'h00;
            scr_pal[r][c]  = p;
          end
        end
        slot_ptr = '0;
        cur_col  = {1'b0, org_col};
        cur_row  = {2'b00, org_row};
        cells_due.push_back(cell_report(8'd0, 8'd0, STAT_OK));
      end
      default: begin
        col = {1'b0, it.pos_x};
        row = {1'b0, it.pos_y};
        cells_due.push_back(cell_report(col, row, in_store(col, row) ? STAT_OK : STAT_OUTSIDE));
      end
    endcase
  endfunction

  // Driver: hold the oldest pending item until it is taken, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_cell(cmd_backlog.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid_i <= 1'b1;
          in_item_i  <= cmd_backlog[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls at random outside the steady stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor: compare each taken result with the oldest expected cell.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      cells_seen++;
      if (cells_due.size() == 0) begin
        bad_cells++;
        if (bad_cells <= 10)
          $display("result %0d arrived with no item outstanding: col %0d row %0d",
                   cells_seen, out_item_o.cell_col, out_item_o.cell_row);
      end else begin
        want = cells_due.pop_front();
        if (out_item_o.cell_col !== want.cell_col || out_item_o.cell_row !== want.cell_row ||
            out_item_o.cell_char !== want.cell_char ||
            out_item_o.cell_palette !== want.cell_palette ||
            out_item_o.cell_fg !== want.cell_fg || out_item_o.cell_bg !== want.cell_bg ||
            out_item_o.status !== want.status) begin
          bad_cells++;
          if (bad_cells <= 10) begin
            $display("result %0d mismatch", cells_seen);
            $display("  expected col %0d row %0d char %h pal %0d fg %h bg %h status %0d",
                     want.cell_col, want.cell_row, want.cell_char, want.cell_palette,
                     want.cell_fg, want.cell_bg, want.status);
            $display("  actual   col %0d row %0d char %h pal %0d fg %h bg %h status %0d",
                     out_item_o.cell_col, out_item_o.cell_row, out_item_o.cell_char,
                     out_item_o.cell_palette, out_item_o.cell_fg, out_item_o.cell_bg,
                     out_item_o.status);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb_text_console_cell_writer failed");
      $finish;
    end
  end

  task automatic queue_cmd(logic [1:0] cmd, logic [7:0] ch, logic [6:0] px, logic [6:0] py);
    in_item_t it;
    it.cmd   = cmd;
    it.ch    = ch;
    it.pos_x = px;
    it.pos_y = py;
    cmd_backlog.push_back(it);
  endtask

  // Register write through the configuration channel; the shadow follows it.
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ORIGIN_COL: org_col  = data[6:0];
      CFG_ORIGIN_ROW: org_row  = data[5:0];
      CFG_LINE_LIMIT: wrap_col = data[6:0];
      CFG_ROW_LIMIT:  wrap_row = data[5:0];
      CFG_FG_COLOR:   fg_word  = data;
      CFG_BG_COLOR:   bg_word  = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || cells_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Random command, mostly writes near the text area with readable characters.
  function automatic in_item_t random_cmd();
    in_item_t it;
    int       k, c;
    k        = $urandom_range(99);
    c        = $urandom_range(99);
    it.ch    = 8'($urandom);
    it.pos_x = 7'($urandom);
    it.pos_y = 7'($urandom);
    if (k < 60) begin
      it.cmd = CMD_WRITE;
      if (c < 70)      it.ch = 8'($urandom_range(CHAR_TILDE, CHAR_SPACE));
      else if (c < 78) it.ch = 8'h00;
      else if (c < 86) it.ch = (c < 82) ? CHAR_CR : CHAR_LF;
    end else if (k < 72) begin
      it.cmd = CMD_SET;
      if (c < 80) begin
        it.pos_x = 7'($urandom_range(79 - int'(org_col)));
        it.pos_y = 7'($urandom_range(34 - int'(org_row)));
      end
    end else if (k < 98) begin
      it.cmd = CMD_READ;
      if (c < 70) begin
        it.pos_x = 7'($urandom_range(79, int'(org_col)));
        it.pos_y = 7'($urandom_range(34, int'(org_row)));
      end
    end else begin
      it.cmd = CMD_CLEAR;
    end
    return it;
  endfunction

  initial begin
    int oc, orr, n;
    // Shadow state after reset.
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        scr_char[r][c] = 8'h00;
        scr_pal[r][c]  = 5'd0;
      end
    end
    for (int i = 0; i < PAL_SLOTS; i++) begin
      pal_fg[i] = '0;
      pal_bg[i] = '0;
    end
    slot_ptr = '0;
    cur_col  = RST_CURSOR_COL;
    cur_row  = RST_CURSOR_ROW;
    org_col  = RST_ORIGIN_COL;
    org_row  = RST_ORIGIN_ROW;
    wrap_col = RST_LINE_LIMIT;
    wrap_row = RST_ROW_LIMIT;
    fg_word  = RST_FG_COLOR;
    bg_word  = RST_BG_COLOR;
    fg_pool[0] = 32'h0000_0000;
    fg_pool[1] = 32'hFFFF_FFFF;
    fg_pool[2] = RST_FG_COLOR;
    for (int i = 3; i < 12; i++) fg_pool[i] = $urandom;
    bg_pool[0] = 32'h0000_0000;
    bg_pool[1] = 32'hFFFF_FFFF;
    bg_pool[2] = $urandom;
    bg_pool[3] = $urandom;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset configuration; the cursor starts at (24,16).
    queue_cmd(CMD_READ, 8'h00, 7'd0, 7'd0);
    queue_cmd(CMD_READ, 8'hFF, 7'd79, 7'd34);
    queue_cmd(CMD_READ, 8'h00, 7'd80, 7'd34);
    queue_cmd(CMD_READ, 8'h00, 7'd0, 7'd35);
    queue_cmd(CMD_READ, 8'h00, 7'd127, 7'd127);
    queue_cmd(CMD_WRITE, 8'h41, 7'd0, 7'd0);
    queue_cmd(CMD_WRITE, 8'h00, 7'd0, 7'd0);
    queue_cmd(CMD_WRITE, 8'h7F, 7'd0, 7'd0);
    queue_cmd(CMD_WRITE, 8'hFF, 7'd127, 7'd127);
    queue_cmd(CMD_WRITE, 8'h1F, 7'd0, 7'd0);
    queue_cmd(CMD_WRITE, CHAR_SPACE, 7'd0, 7'd0);
    queue_cmd(CMD_WRITE, CHAR_TILDE, 7'd0, 7'd0);
    queue_cmd(CMD_WRITE, CHAR_CR, 7'd0, 7'd0);
    queue_cmd(CMD_WRITE, CHAR_LF, 7'd0, 7'd0);
    // Last cell before both limits: one write wraps the line and the screen.
    queue_cmd(CMD_SET, 8'h00, 7'd70, 7'd30);
    queue_cmd(CMD_WRITE, 8'h5A, 7'd0, 7'd0);
    queue_cmd(CMD_SET, 8'h00, 7'd74, 7'd33);
    queue_cmd(CMD_WRITE, 8'h71, 7'd0, 7'd0);
    // Cursor far outside the store; the write is dropped.
    queue_cmd(CMD_SET, 8'h00, 7'd127, 7'd127);
    queue_cmd(CMD_WRITE, 8'h78, 7'd0, 7'd0);
    queue_cmd(CMD_SET, 8'h00, 7'd0, 7'd0);
    queue_cmd(CMD_CLEAR, 8'h00, 7'd0, 7'd0);
    queue_cmd(CMD_READ, 8'h00, 7'd79, 7'd34);
    queue_cmd(CMD_READ, 8'h00, 7'd5, 7'd1);
    wait_idle();

    // Random phases, each under its own geometry and color pair.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      steady = (ph >= 12 && ph < 20);
      if (ph % 8 == 1) begin
        oc = 0; orr = 0;
        set_reg(CFG_LINE_LIMIT, 32'd1);
        set_reg(CFG_ROW_LIMIT, 32'd1);
      end else if (ph % 8 == 3) begin
        oc = 79; orr = 34;
        set_reg(CFG_LINE_LIMIT, 32'd80);
        set_reg(CFG_ROW_LIMIT, 32'd35);
      end else if (ph % 8 == 5) begin
        oc = 0; orr = 0;
        set_reg(CFG_LINE_LIMIT, 32'd80);
        set_reg(CFG_ROW_LIMIT, 32'd35);
      end else if ($urandom_range(3) == 0) begin
        oc  = $urandom_range(79);
        orr = $urandom_range(34);
        set_reg(CFG_LINE_LIMIT, 32'($urandom_range(80, 1)));
        set_reg(CFG_ROW_LIMIT, 32'($urandom_range(35, 1)));
      end else begin
        oc  = $urandom_range(60);
        orr = $urandom_range(25);
        set_reg(CFG_LINE_LIMIT, 32'($urandom_range(80, oc + 1)));
        set_reg(CFG_ROW_LIMIT, 32'($urandom_range(35, orr + 1)));
      end
      set_reg(CFG_ORIGIN_COL, 32'(oc));
      set_reg(CFG_ORIGIN_ROW, 32'(orr));
      set_reg(CFG_FG_COLOR, fg_pool[$urandom_range(11)]);
      set_reg(CFG_BG_COLOR, bg_pool[$urandom_range(3)]);

      // Start each phase at the new origin, then random traffic.
      queue_cmd(CMD_SET, 8'($urandom), 7'd0, 7'd0);
      n = $urandom_range(47, 25);
      for (int i = 0; i < n; i++) cmd_backlog.push_back(random_cmd());
      wait_idle();
    end

    steady = 1'b0;
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (bad_cells == 0 && cells_due.size() == 0) begin
      $display("tb_text_console_cell_writer passed");
    end else begin
      $display("tb_text_console_cell_writer failed");
    end
    $finish;
  end

endmodule
